>>> rtl/core/rnks_pkg.sv
// rnks_pkg: shared types and constants of the radius nearest-k selector
`timescale 1ns / 1ps

package rnks_pkg;

	localparam int COORD_W   = 16;   // position field width
	localparam int ID_PORT_W = 16;   // index field width on the ports
	localparam int COUNT_W   = 6;    // kept_count field width

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture an accepted input item
		logic square;      // register the three axis squares
		logic wr_app;      // append candidate at fill position
		logic wr_evict;    // overwrite farthest slot
		logic ptr_clear;   // reset slot read pointer
		logic ptr_inc;     // advance slot read pointer
		logic rd_en;       // read slot memories at pointer
		logic scan;        // read belongs to a farthest-slot rescan
		logic set_empty;   // present the empty-list marker
		logic clear_run;   // forget the kept list
	} ctrl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic self_cand;   // candidate is the query itself
		logic in_range;    // squared distance below one radius squared
		logic full;        // all slots taken
		logic nearer;      // candidate strictly nearer than farthest slot
		logic run_end;     // captured item closes the run
		logic empty;       // nothing kept
		logic ptr_end;     // pointer on the last slot
		logic list_last;   // result on the output is the final one
	} ctrl_sts_t;

endpackage

>>> rtl/core/rnks_dpath.sv
// rnks_dpath: distance arithmetic, slot memories, farthest tracking and result fields
`timescale 1ns / 1ps

module rnks_dpath #(
	parameter int MAX_KEPT   = 32,
	parameter int FRAC_BITS  = 11,
	parameter int INDEX_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rnks_pkg::ctrl_cmd_t                cmd,
	output rnks_pkg::ctrl_sts_t                sts,
	input  logic [rnks_pkg::ID_PORT_W-1:0]     query_index,
	input  logic [rnks_pkg::COORD_W-1:0]       query_x,
	input  logic [rnks_pkg::COORD_W-1:0]       query_y,
	input  logic [rnks_pkg::COORD_W-1:0]       query_z,
	input  logic [rnks_pkg::ID_PORT_W-1:0]     cand_index,
	input  logic [rnks_pkg::COORD_W-1:0]       cand_x,
	input  logic [rnks_pkg::COORD_W-1:0]       cand_y,
	input  logic [rnks_pkg::COORD_W-1:0]       cand_z,
	input  logic                               run_end,
	output logic [rnks_pkg::ID_PORT_W-1:0]     neighbour_id,
	output logic [rnks_pkg::COUNT_W-1:0]       kept_count,
	output logic                               list_empty,
	output logic                               list_last
);

	localparam int SW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW    = $clog2(MAX_KEPT + 1);
	localparam int DW    = 2 * FRAC_BITS;
	localparam int CRD   = rnks_pkg::COORD_W;
	localparam int SQ_W  = 2 * CRD;
	localparam int SUM_W = SQ_W + 2;

	function automatic logic [CRD-1:0] abs_diff(input logic [CRD-1:0] a, input logic [CRD-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// captured item
	logic [INDEX_BITS-1:0] qid_s1, cid_s1;
	logic [CRD-1:0]        qx_s1, qy_s1, qz_s1, cx_s1, cy_s1, cz_s1;
	logic                  last_s1;

	// squared axis differences
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [CRD-1:0]  dx, dy, dz;
	logic [SUM_W-1:0] sum_d;
	logic [DW-1:0]    cand_dsq;

	// slot storage and tracking
	logic [INDEX_BITS-1:0] id_mem   [MAX_KEPT];
	logic [DW-1:0]         dist_mem [MAX_KEPT];
	logic [INDEX_BITS-1:0] rd_id_q;
	logic [DW-1:0]         rd_dist_q;
	logic [SW-1:0]         rd_addr_q;
	logic                  scan_vld_q;
	logic [CW-1:0]         fill_q;
	logic [SW-1:0]         far_slot_q;
	logic [DW-1:0]         far_dist_q;
	logic [SW-1:0]         ptr_q;
	logic                  empty_q;
	logic [SW-1:0]         wr_addr;
	logic                  wr_en;
	logic [CW+rnks_pkg::COUNT_W-1:0] cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s1 <= 1'b0;
		end else if (cmd.load) begin
			last_s1 <= run_end;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qid_s1 <= query_index[INDEX_BITS-1:0];
			cid_s1 <= cand_index[INDEX_BITS-1:0];
			qx_s1  <= query_x;
			qy_s1  <= query_y;
			qz_s1  <= query_z;
			cx_s1  <= cand_x;
			cy_s1  <= cand_y;
			cz_s1  <= cand_z;
		end
		if (cmd.square) begin
			sqx_s2 <= SQ_W'(dx) * SQ_W'(dx);
			sqy_s2 <= SQ_W'(dy) * SQ_W'(dy);
			sqz_s2 <= SQ_W'(dz) * SQ_W'(dz);
		end
	end

	assign dx = abs_diff(qx_s1, cx_s1);
	assign dy = abs_diff(qy_s1, cy_s1);
	assign dz = abs_diff(qz_s1, cz_s1);

	assign sum_d    = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	assign cand_dsq = sum_d[DW-1:0];

	assign wr_en   = cmd.wr_app | cmd.wr_evict;
	assign wr_addr = cmd.wr_evict ? far_slot_q : fill_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr]   <= cid_s1;
			dist_mem[wr_addr] <= cand_dsq;
		end
		if (cmd.rd_en) begin
			rd_id_q   <= id_mem[ptr_q];
			rd_dist_q <= dist_mem[ptr_q];
			rd_addr_q <= ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			far_slot_q <= '0;
			far_dist_q <= '0;
			ptr_q      <= '0;
			empty_q    <= 1'b0;
			scan_vld_q <= 1'b0;
		end else begin
			scan_vld_q <= cmd.rd_en & cmd.scan;
			if (cmd.ptr_clear) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.clear_run) begin
				fill_q     <= '0;
				far_slot_q <= '0;
				far_dist_q <= '0;
				empty_q    <= 1'b0;
			end else begin
				if (cmd.wr_app) begin
					fill_q <= fill_q + 1'b1;
					// strict compare keeps the earlier slot on a tie
					if (cand_dsq > far_dist_q) begin
						far_dist_q <= cand_dsq;
						far_slot_q <= fill_q[SW-1:0];
					end
				end
				// rescan restarts from zero, far slot kept if nothing beats it
				if (cmd.wr_evict) begin
					far_dist_q <= '0;
				end
				if (scan_vld_q && (rd_dist_q > far_dist_q)) begin
					far_dist_q <= rd_dist_q;
					far_slot_q <= rd_addr_q;
				end
				if (cmd.set_empty) begin
					empty_q <= 1'b1;
				end
			end
		end
	end

	assign sts.self_cand = (qid_s1 == cid_s1);
	assign sts.in_range  = ((sum_d >> DW) == '0);
	assign sts.full      = (fill_q == CW'(MAX_KEPT));
	assign sts.nearer    = (cand_dsq < far_dist_q);
	assign sts.run_end   = last_s1;
	assign sts.empty     = (fill_q == '0);
	assign sts.ptr_end   = (ptr_q == SW'(MAX_KEPT - 1));
	assign sts.list_last = empty_q || (((CW + 1)'(rd_addr_q) + 1'b1) == (CW + 1)'(fill_q));

	assign cnt_ext      = {{rnks_pkg::COUNT_W{1'b0}}, fill_q};
	assign kept_count   = cnt_ext[rnks_pkg::COUNT_W-1:0];
	assign neighbour_id = empty_q ? '0 : rnks_pkg::ID_PORT_W'(rd_id_q);
	assign list_empty   = empty_q;
	assign list_last    = sts.list_last;

endmodule

>>> rtl/core/rnks_ctrl.sv
// rnks_ctrl: sequencing state machine of the radius nearest-k selector
`timescale 1ns / 1ps

module rnks_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  rnks_pkg::ctrl_sts_t sts,
	output rnks_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SQUARE    = 3'd1;
	localparam logic [2:0] ST_DECIDE    = 3'd2;
	localparam logic [2:0] ST_SCAN      = 3'd3;
	localparam logic [2:0] ST_SCAN_TAIL = 3'd4;
	localparam logic [2:0] ST_EMIT_RD   = 3'd5;
	localparam logic [2:0] ST_OUT       = 3'd6;

	logic [2:0] state_q, state_nx;
	logic       keep;

	assign keep = !sts.self_cand && sts.in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_nx   = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.ptr_clear = 1'b1;
				if (keep && !sts.full) begin
					cmd.wr_app = 1'b1;
				end
				if (keep && sts.full && sts.nearer) begin
					cmd.wr_evict = 1'b1;
					state_nx     = ST_SCAN;
				end else if (sts.run_end) begin
					state_nx = ST_EMIT_RD;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.scan    = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_end) begin
					state_nx = ST_SCAN_TAIL;
				end
			end
			ST_SCAN_TAIL: begin
				// last rescan compare lands on this edge
				cmd.ptr_clear = 1'b1;
				state_nx      = sts.run_end ? ST_EMIT_RD : ST_IDLE;
			end
			ST_EMIT_RD: begin
				if (sts.empty) begin
					cmd.set_empty = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					if (sts.list_last) begin
						cmd.clear_run = 1'b1;
						state_nx      = ST_IDLE;
					end else begin
						// fetch the next slot as this item leaves
						cmd.rd_en   = 1'b1;
						cmd.ptr_inc = 1'b1;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/radius_nearest_k_selector_top.sv
// Block usage:
// The input channel (in_valid / in_stall) takes one candidate item per cycle at most;
// each item carries the query index and position, one candidate index and position,
// and run_end on the last candidate of a query. The output channel (out_valid /
// out_stall) delivers the kept neighbour list in slot order, kept_count repeated on
// every item and list_last on the final one, or a single item with list_empty set
// when nothing was kept.
// Items are handled one at a time. A candidate that is appended or rejected holds
// in_stall high through the SQUARE and DECIDE states after acceptance, so the next
// item waits until it is through. A candidate that replaces the farthest slot adds
// the SCAN and SCAN_TAIL states, a rescan of the distance memory one slot per cycle. After
// a run_end item the first result follows the EMIT_RD read, after any rescan; the rest
// follow one per cycle while out_stall is low, the slot memory read one result ahead.
// While out_stall is high the current result holds and no input item is accepted;
// the next run starts once the final result of the list has been taken.
// Reset clears the kept count and farthest-slot tracking; the slot memories need no
// clearing because only slots written in the current run are ever read.
`timescale 1ns / 1ps

module radius_nearest_k_selector_top #(
	parameter int MAX_KEPT   = 32,
	parameter int FRAC_BITS  = 11,
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] query_index,
	input  logic [15:0] query_x,
	input  logic [15:0] query_y,
	input  logic [15:0] query_z,
	input  logic [15:0] cand_index,
	input  logic [15:0] cand_x,
	input  logic [15:0] cand_y,
	input  logic [15:0] cand_z,
	input  logic        run_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] neighbour_id,
	output logic [5:0]  kept_count,
	output logic        list_empty,
	output logic        list_last
);

	rnks_pkg::ctrl_cmd_t cmd;
	rnks_pkg::ctrl_sts_t sts;

	rnks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rnks_dpath #(
		.MAX_KEPT   (MAX_KEPT),
		.FRAC_BITS  (FRAC_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.query_index  (query_index),
		.query_x      (query_x),
		.query_y      (query_y),
		.query_z      (query_z),
		.cand_index   (cand_index),
		.cand_x       (cand_x),
		.cand_y       (cand_y),
		.cand_z       (cand_z),
		.run_end      (run_end),
		.neighbour_id (neighbour_id),
		.kept_count   (kept_count),
		.list_empty   (list_empty),
		.list_last    (list_last)
	);

	// no item enters while a list is being delivered
	a_no_accept_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("item accepted while a result is pending");

	// the empty marker is a single final item with zero count
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_empty) |-> (list_last && kept_count == '0 && neighbour_id == '0))
		else $error("malformed empty marker");

	// append and evict never write the slot memories together
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_app && cmd.wr_evict))
		else $error("append and evict in the same cycle");

	// delivery stops after the final item of a list
	a_list_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && list_last) |=> (!out_valid && !in_stall))
		else $error("output continues after final item");

endmodule
